[sv/lmlt_pkg.sv]
`default_nettype none

package lmlt_pkg;

    // Line timing constants
    localparam logic [9:0] LINE_CYCLES  = 10'd456;
    localparam logic [9:0] OAM_START    = 10'd376;
    localparam logic [9:0] XFER_START   = 10'd204;
    localparam logic [7:0] LAST_VISIBLE = 8'd143;
    localparam logic [7:0] VBLANK_LINE  = 8'd145;
    localparam logic [7:0] WRAP_LINE    = 8'd153;

    // Display modes
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    // Register indexes
    localparam logic [7:0] REG_LYC_COMPARE = 8'd0;
    localparam logic [7:0] REG_HBLANK_IEN  = 8'd1;
    localparam logic [7:0] REG_OAM_IEN     = 8'd2;
    localparam logic [7:0] REG_LYC_IEN     = 8'd3;

    typedef struct packed {
        logic [7:0] lyc_compare;
        logic       hblank_irq_enable;
        logic       oam_irq_enable;
        logic       lyc_irq_enable;
    } cfg_t;

    typedef struct packed {
        logic [7:0] line_count;
        mode_t      mode_bits;
        logic [9:0] line_countdown;
        logic       coincidence_flag;
    } timing_state_t;

    typedef struct packed {
        mode_t      lcd_mode;
        logic [7:0] line_number;
        logic       coincidence;
        logic       vblank_request;
        logic       status_request;
        logic       render_valid;
        logic [7:0] render_line;
        logic       frame_done;
    } result_t;

endpackage

`default_nettype wire

[sv/lmlt_cfg.sv]
`default_nettype none

module lmlt_cfg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [7:0]        wr_index,
    input  wire logic [7:0]        wr_data,
    output lmlt_pkg::cfg_t         cfg
);

    lmlt_pkg::cfg_t cfg_reg;
    lmlt_pkg::cfg_t cfg_next;

    // Decode the register index; drop writes to unknown indexes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                lmlt_pkg::REG_LYC_COMPARE: cfg_next.lyc_compare       = wr_data;
                lmlt_pkg::REG_HBLANK_IEN:  cfg_next.hblank_irq_enable = wr_data[0];
                lmlt_pkg::REG_OAM_IEN:     cfg_next.oam_irq_enable    = wr_data[0];
                lmlt_pkg::REG_LYC_IEN:     cfg_next.lyc_irq_enable    = wr_data[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[sv/lmlt_step.sv]
`default_nettype none

module lmlt_step (
    input  wire lmlt_pkg::timing_state_t cur,
    input  wire lmlt_pkg::cfg_t          cfg,
    input  wire logic [7:0]              cycles,
    output lmlt_pkg::timing_state_t      nxt,
    output lmlt_pkg::result_t            res
);

    always_comb
    begin
        logic [9:0]      cd;
        logic [7:0]      line_inc;
        logic            enabled;
        lmlt_pkg::mode_t mode;

        nxt = cur;
        res = '0;

        // Count down, saturating at zero
        if (cur.line_countdown > {2'b00, cycles})
        begin
            cd = cur.line_countdown - {2'b00, cycles};
        end
        else
        begin
            cd = '0;
        end
        nxt.line_countdown = cd;

        // Pick the mode from the countdown; request on entry when enabled
        enabled = 1'b0;
        if (cur.line_count > lmlt_pkg::LAST_VISIBLE)
        begin
            mode = lmlt_pkg::MODE_VBLANK;
        end
        else
        begin
            if (cd >= lmlt_pkg::OAM_START)
            begin
                mode    = lmlt_pkg::MODE_OAM;
                enabled = cfg.oam_irq_enable;
            end
            else if (cd >= lmlt_pkg::XFER_START)
            begin
                mode = lmlt_pkg::MODE_XFER;
            end
            else
            begin
                mode    = lmlt_pkg::MODE_HBLANK;
                enabled = cfg.hblank_irq_enable;
            end
            res.status_request = enabled && (cur.mode_bits != mode);
        end
        nxt.mode_bits = mode;

        // Reload at line end and advance the line
        line_inc = cur.line_count + 8'd1;
        if (cd == '0)
        begin
            nxt.line_countdown = lmlt_pkg::LINE_CYCLES;
            nxt.line_count     = line_inc;
            if (line_inc == lmlt_pkg::VBLANK_LINE)
            begin
                res.vblank_request = 1'b1;
                nxt.mode_bits      = lmlt_pkg::MODE_VBLANK;
            end
            else
            begin
                if (line_inc < lmlt_pkg::VBLANK_LINE)
                begin
                    res.render_valid = 1'b1;
                    res.render_line  = cur.line_count;
                end
                if (line_inc == lmlt_pkg::WRAP_LINE)
                begin
                    res.frame_done = 1'b1;
                    nxt.line_count = '0;
                end
            end
        end

        // Coincidence check, skipped on the step that reaches vblank
        if (!res.vblank_request)
        begin
            nxt.coincidence_flag = (cfg.lyc_compare == nxt.line_count);
            if (nxt.coincidence_flag && cfg.lyc_irq_enable)
            begin
                res.status_request = 1'b1;
            end
        end

        res.lcd_mode    = nxt.mode_bits;
        res.line_number = nxt.line_count;
        res.coincidence = nxt.coincidence_flag;
    end

endmodule

`default_nettype wire

[sv/lcd_mode_line_timing.sv]
`default_nettype none

// LCD mode and line timing sequencer. Each input word carries the machine
// cycles elapsed since the previous word; the block counts them off a line
// countdown reloaded to 456 and returns one result word per input word with
// the display mode, line counter, coincidence flag and the vblank, status,
// render and end-of-frame strobes raised by that step. An input word is
// registered, stepped through one stage of compare-and-count logic and held
// in an output register. A word enters on every clock and the throughput
// is one word per cycle while the output register is free or drains;
// otherwise the input register holds its word and the input stalls.
// Configuration writes (index 0 compare line, 1 hblank enable, 2 OAM
// enable, 3 compare enable) are always ready and are meant for when no
// word is in flight.
module lcd_mode_line_timing (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_index,
    input  wire logic [7:0] cfg_data,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] cycles_elapsed,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      lcd_mode,
    output logic [7:0]      line_number,
    output logic            coincidence,
    output logic            vblank_request,
    output logic            status_request,
    output logic            render_valid,
    output logic [7:0]      render_line,
    output logic            frame_done
);

    lmlt_pkg::cfg_t          cfg;
    lmlt_pkg::timing_state_t state_reg;
    lmlt_pkg::timing_state_t state_next;
    lmlt_pkg::result_t       res_next;
    lmlt_pkg::result_t       res_reg;

    logic       in_valid_reg;
    logic [7:0] cycles_reg;
    logic       out_valid_reg;
    logic       advance;

    // Configuration registers
    assign cfg_ready = 1'b1;

    lmlt_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Step logic
    lmlt_step u_step (
        .cur    (state_reg),
        .cfg    (cfg),
        .cycles (cycles_reg),
        .nxt    (state_next),
        .res    (res_next)
    );

    // Handshake: move a word on when the result register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Hold control and timing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{line_count:       '0,
                               mode_bits:        lmlt_pkg::MODE_HBLANK,
                               line_countdown:   lmlt_pkg::LINE_CYCLES,
                               coincidence_flag: 1'b0};
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cycles_reg <= cycles_elapsed;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign lcd_mode       = res_reg.lcd_mode;
    assign line_number    = res_reg.line_number;
    assign coincidence    = res_reg.coincidence;
    assign vblank_request = res_reg.vblank_request;
    assign status_request = res_reg.status_request;
    assign render_valid   = res_reg.render_valid;
    assign render_line    = res_reg.render_line;
    assign frame_done     = res_reg.frame_done;

    // Countdown always sits in 1..456 between words
    a_countdown_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.line_countdown != '0) &&
        (state_reg.line_countdown <= lmlt_pkg::LINE_CYCLES))
        else $error("line countdown out of range");

    // End of frame leaves the line counter at zero
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && res_reg.frame_done) |-> (res_reg.line_number == '0))
        else $error("frame end without line wrap");

    // Vblank entry lands on line 145 in vblank mode
    a_vblank_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && res_reg.vblank_request) |->
        ((res_reg.line_number == lmlt_pkg::VBLANK_LINE) &&
         (res_reg.lcd_mode == lmlt_pkg::MODE_VBLANK)))
        else $error("vblank request off line 145");

    // A render strobe names a visible line just finished
    a_render_line: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && res_reg.render_valid) |->
        ((res_reg.render_line <= lmlt_pkg::LAST_VISIBLE) &&
         (res_reg.frame_done == 1'b0)))
        else $error("render strobe on a hidden line");

    // A stepped word changes the state only when it advances
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("timing state moved without a word");

endmodule

`default_nettype wire

[tb/tb_lcd_mode_line_timing.sv]
module tb_lcd_mode_line_timing;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] REG_UNMAPPED = 8'hFF;
    localparam int         PHASES       = 8;
    localparam int         PHASE_WORDS  = 240;
    localparam int         STALL_LEN    = 300;
    localparam int         QUIET_LIMIT  = 2000;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cfg_valid      = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index      = '0;
    logic [7:0] cfg_data       = '0;
    logic       in_valid       = 1'b0;
    logic       in_ready;
    logic [7:0] cycles_elapsed = '0;
    logic       out_valid;
    logic       out_ready      = 1'b0;
    logic [1:0] lcd_mode;
    logic [7:0] line_number;
    logic       coincidence;
    logic       vblank_request;
    logic       status_request;
    logic       render_valid;
    logic [7:0] render_line;
    logic       frame_done;

    // Words waiting to be sent and results still owed by the block
    logic [7:0]        cycle_reports [$];
    lmlt_pkg::result_t timing_due [$];

    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int stall_reqs   = 0;
    int stall_taken  = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;
    int fail_count   = 0;

    // Register copies
    logic [7:0] lyc_cmp = '0;
    logic       hb_en   = 1'b0;
    logic       oam_en  = 1'b0;
    logic       lyc_en  = 1'b0;

    // Timing state copies
    logic [7:0]      line_ctr  = '0;
    lmlt_pkg::mode_t cur_mode  = lmlt_pkg::MODE_HBLANK;
    logic [9:0]      countdown = lmlt_pkg::LINE_CYCLES;
    logic            coin      = 1'b0;

    lcd_mode_line_timing dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cycles_elapsed (cycles_elapsed),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .lcd_mode       (lcd_mode),
        .line_number    (line_number),
        .coincidence    (coincidence),
        .vblank_request (vblank_request),
        .status_request (status_request),
        .render_valid   (render_valid),
        .render_line    (render_line),
        .frame_done     (frame_done)
    );

    always #2 clk = ~clk;

    // Advance the line timing by one cycle report and return the strobes it raises
    function automatic lmlt_pkg::result_t step_line_timing(input logic [7:0] cyc);
        lmlt_pkg::result_t r;
        lmlt_pkg::mode_t   prev;
        logic              irq_on;
        logic              keep_coin;
        r = '0;
        keep_coin = 1'b0;
        // Count down, saturating at zero
        if (countdown > {2'b00, cyc})
            countdown = countdown - {2'b00, cyc};
        else
            countdown = '0;
        if (line_ctr > lmlt_pkg::LAST_VISIBLE) begin
            cur_mode = lmlt_pkg::MODE_VBLANK;
        end
        else begin
            prev = cur_mode;
            if (countdown >= lmlt_pkg::OAM_START) begin
                cur_mode = lmlt_pkg::MODE_OAM;
                irq_on   = oam_en;
            end
            else if (countdown >= lmlt_pkg::XFER_START) begin
                cur_mode = lmlt_pkg::MODE_XFER;
                irq_on   = 1'b0;
            end
            else begin
                cur_mode = lmlt_pkg::MODE_HBLANK;
                irq_on   = hb_en;
            end
            if (irq_on && prev != cur_mode)
                r.status_request = 1'b1;
        end
        // Reload and move to the next line
        if (countdown == '0) begin
            countdown = lmlt_pkg::LINE_CYCLES;
            line_ctr  = line_ctr + 8'd1;
            if (line_ctr == lmlt_pkg::VBLANK_LINE) begin
                r.vblank_request = 1'b1;
                cur_mode         = lmlt_pkg::MODE_VBLANK;
                keep_coin        = 1'b1;
            end
            else begin
                if (line_ctr < lmlt_pkg::VBLANK_LINE) begin
                    r.render_valid = 1'b1;
                    r.render_line  = line_ctr - 8'd1;
                end
                if (line_ctr == lmlt_pkg::WRAP_LINE) begin
                    r.frame_done = 1'b1;
                    line_ctr     = '0;
                end
            end
        end
        // Compare is skipped on the step that reaches the vblank line
        if (!keep_coin) begin
            coin = (lyc_cmp == line_ctr);
            if (coin && lyc_en)
                r.status_request = 1'b1;
        end
        r.lcd_mode    = cur_mode;
        r.line_number = line_ctr;
        r.coincidence = coin;
        return r;
    endfunction

    function automatic void note_reg_write(input logic [7:0] idx, input logic [7:0] val);
        case (idx)
            lmlt_pkg::REG_LYC_COMPARE: lyc_cmp = val;
            lmlt_pkg::REG_HBLANK_IEN:  hb_en   = val[0];
            lmlt_pkg::REG_OAM_IEN:     oam_en  = val[0];
            lmlt_pkg::REG_LYC_IEN:     lyc_en  = val[0];
            default:                   ;
        endcase
    endfunction

    // Mostly full-range reports, some short ones to dwell in OAM and transfer, some at 0 or 255
    function automatic logic [7:0] next_report();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            return 8'($urandom_range(0, 24));
        else if (sel < 32)
            return 8'($urandom_range(0, 1) ? 255 : 0);
        else
            return 8'($urandom_range(0, 255));
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Write all registers back to back, plus one write to an unmapped index
    task automatic write_settings(input logic [7:0] lyc, input logic [7:0] hb,
                                  input logic [7:0] oam, input logic [7:0] ly);
        logic [7:0] idx [5];
        logic [7:0] val [5];
        int         i;
        idx = '{lmlt_pkg::REG_LYC_COMPARE, lmlt_pkg::REG_HBLANK_IEN,
                lmlt_pkg::REG_OAM_IEN, lmlt_pkg::REG_LYC_IEN, REG_UNMAPPED};
        val = '{lyc, hb, oam, ly, 8'($urandom_range(0, 255))};
        for (i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            note_reg_write(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Hold until every sent word has come back, then let the pipeline settle
    task automatic wait_drained();
        while (cycle_reports.size() != 0 || in_valid || timing_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Sender: offer the next word, predict on acceptance
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid       <= 1'b0;
            cycles_elapsed <= '0;
        end
        else begin
            if (in_valid && in_ready)
                timing_due.push_back(step_line_timing(cycles_elapsed));
            if (!in_valid || in_ready) begin
                if (cycle_reports.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    in_valid       <= 1'b1;
                    cycles_elapsed <= cycle_reports.pop_front();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result word against the oldest prediction
    always @(posedge clk or negedge rst_n) begin
        lmlt_pkg::result_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (timing_due.size() == 0) begin
                    $error("result word with no prediction waiting");
                    fail_count++;
                end
                else begin
                    want = timing_due.pop_front();
                    check_field("lcd_mode", 8'(want.lcd_mode), 8'(lcd_mode));
                    check_field("line_number", want.line_number, line_number);
                    check_field("coincidence", 8'(want.coincidence), 8'(coincidence));
                    check_field("vblank_request", 8'(want.vblank_request),
                                8'(vblank_request));
                    check_field("status_request", 8'(want.status_request),
                                8'(status_request));
                    check_field("render_valid", 8'(want.render_valid), 8'(render_valid));
                    check_field("render_line", want.render_line, render_line);
                    check_field("frame_done", 8'(want.frame_done), 8'(frame_done));
                end
            end
            // Long hold-off on request, otherwise random back-pressure
            if (stall_reqs != stall_taken) begin
                stall_taken = stall_reqs;
                stall_left  = STALL_LEN;
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
            end
        end
    end

    // Drop the run if nothing moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("lcd_mode_line_timing test failed");
                $finish;
            end
        end
    end

    initial begin
        int         k;
        int         n;
        logic [7:0] lyc;
        logic [7:0] en_hb;
        logic [7:0] en_oam;
        logic [7:0] en_ly;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: mode entries, saturation, field extremes
        send_gap_pct <= 18;
        recv_gap_pct <= 58;
        write_settings(8'd0, 8'd1, 8'd1, 8'd1);
        cycle_reports = {8'd0, 8'd80, 8'd1, 8'd171, 8'd1, 8'd202, 8'd1, 8'd255, 8'd255,
                         8'd0, 8'd79, 8'd1, 8'd255, 8'd255, 8'h55, 8'hAA, 8'd128,
                         8'd64, 8'd32, 8'd16, 8'd8, 8'd4, 8'd2};
        wait_drained();

        // Random phases with changing settings and idle patterns
        for (k = 1; k < PHASES; k++) begin
            if (k >= 6) begin
                send_gap_pct <= 0;
                recv_gap_pct <= 0;
            end
            else if (k >= 3) begin
                send_gap_pct <= 58;
                recv_gap_pct <= 18;
            end
            case (k)
                1: lyc = 8'd255;
                2: lyc = lmlt_pkg::WRAP_LINE;
                3: lyc = 8'd0;
                default:
                    if (line_ctr >= 8'd100 && line_ctr <= lmlt_pkg::VBLANK_LINE)
                        lyc = k[0] ? lmlt_pkg::VBLANK_LINE : lmlt_pkg::VBLANK_LINE - 8'd1;
                    else
                        lyc = 8'((int'(line_ctr) + $urandom_range(1, 40)) % 154);
            endcase
            if (k == 3) begin
                en_hb  = 8'hFE;
                en_oam = 8'hFE;
                en_ly  = 8'hFE;
            end
            else if (k == 6) begin
                en_hb  = 8'hFF;
                en_oam = 8'hFF;
                en_ly  = 8'hFF;
            end
            else begin
                en_hb  = 8'($urandom_range(0, 255));
                en_oam = 8'($urandom_range(0, 255));
                en_ly  = 8'($urandom_range(0, 255));
            end
            write_settings(lyc, en_hb, en_oam, en_ly);
            for (n = 0; n < PHASE_WORDS; n++)
                cycle_reports.push_back(next_report());
            // Stall the receiver while the sender keeps offering
            if (k == 2)
                stall_reqs <= stall_reqs + 1;
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && timing_due.size() == 0 && cycle_reports.size() == 0)
            $display("lcd_mode_line_timing test passed");
        else
            $display("lcd_mode_line_timing test failed");
        $finish;
    end

endmodule
